// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the bounding circle block.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- hdl/csbc_pkg.sv -----
// Package for the circle set bounding circle block.
// Holds the widths, the capacity and the sequencer state type; depends on nothing.
package csbc_pkg;
	localparam int SetCapacity = 32;
	localparam int IdxW = $clog2(SetCapacity);
	localparam int CntW = $clog2(SetCapacity + 1);
	localparam int SumW = 24 + CntW;
	localparam int DivW = SumW;
	localparam int DivCntW = $clog2(DivW + 1);
	localparam int D2W = 50;
	localparam int RootW = 25;
	localparam int SqCntW = 5;

	typedef enum logic [7:0] {
		ST_LOAD  = 8'b00000001,
		ST_DIVX  = 8'b00000010,
		ST_DIVY  = 8'b00000100,
		ST_READ  = 8'b00001000,
		ST_DIFF  = 8'b00010000,
		ST_SQR   = 8'b00100000,
		ST_ROOT  = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage

// ----- hdl/csbc_div.sv -----
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on csbc_pkg.
module csbc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [csbc_pkg::SumW-1:0] dividend,
	input  logic [csbc_pkg::CntW-1:0]     divisor,
	output logic                          done,
	output logic signed [23:0]            quotient
);
	import csbc_pkg::*;

	logic [DivW-1:0] num_q;
	logic [DivW-1:0] quo_q;
	logic [CntW:0]   rem_q;
	logic [DivCntW-1:0] cnt_q;
	logic            neg_q;
	logic            busy_q;
	logic [CntW:0]   trial;
	logic [DivW-1:0] quo_pos;
	logic [DivW-1:0] quo_fin;

	assign trial = {rem_q[CntW-1:0], num_q[DivW-1]};
	assign quo_pos = {quo_q[DivW-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DivCntW'(DivW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DivCntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SumW-1];
			num_q <= dividend[SumW-1] ? DivW'(-dividend) : DivW'(dividend);
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DivW-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= trial - {1'b0, divisor};
				quo_q <= quo_pos | DivW'(1);
			end else begin
				rem_q <= trial;
				quo_q <= quo_pos;
			end
		end
	end

	assign quo_fin = neg_q ? -quo_q : quo_q;
	assign quotient = quo_fin[23:0];

	`include "assert_macros.svh"
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`ASSERT_IMPL(a_no_restart, clk, arst_n, start, !busy_q)
endmodule

// ----- hdl/csbc_sqrt.sv -----
// Digit-by-digit floor square root, one result bit per cycle.
// Depends on csbc_pkg.
module csbc_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [csbc_pkg::D2W-1:0]   radicand,
	output logic                       done,
	output logic [csbc_pkg::RootW-1:0] root
);
	import csbc_pkg::*;

	logic [D2W-1:0]   val_q;
	logic [RootW+1:0] rem_q;
	logic [RootW-1:0] root_q;
	logic [SqCntW-1:0] cnt_q;
	logic             busy_q;
	logic [RootW+1:0] trial;
	logic [RootW+1:0] test;

	assign trial = {rem_q[RootW-1:0], val_q[D2W-1 -: 2]};
	assign test = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= SqCntW'(RootW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SqCntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[D2W-3:0], 2'b00};
			if (trial >= test) begin
				rem_q <= trial - test;
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;

	`include "assert_macros.svh"
	`ASSERT_NEXT(a_sq_done_pulse, clk, arst_n, done, !done)
	`ASSERT_IMPL(a_sq_no_restart, clk, arst_n, start, !busy_q)
endmodule

// ----- hdl/circle_set_bounding_circle.sv -----
// Circle set bounding circle: top level with store, sequencer and shared units.
// Depends on csbc_pkg, csbc_div, csbc_sqrt and assert_macros.svh.
//
// Usage: circles arrive on the s_axis channel, one per item. An item that is
// not marked last is stored and the block stays ready for the next one. An
// item marked last ends the set: the block drops s_axis_tready, divides the x
// sum and then the y sum by the count (one quotient bit per cycle), and, when
// use_radii is 1, walks the stored circles. Each circle goes through a store
// read, a difference, squaring of dx and then dy on the one 25x25 multiplier
// and a root in the shared 25-step square root unit. The output register is
// loaded in ST_OUT in the same cycle that m_axis_tvalid rises. The result then
// waits on m_axis until taken; the block stays busy until then, and accepts
// nothing while the receiver stalls. Circles beyond 32 are dropped and flagged,
// and a dropped circle marked last still ends the set.
// Reset clears the count, sums and flags and sets use_radii to 1; the circle
// store is not cleared, and only entries written in the current set are read.
// A write on cfg_wr_en updates use_radii and is meant for idle periods only.
module circle_set_bounding_circle (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: center_x [23:0], center_y [47:24], circle_radius [63:48]
	input  logic [63:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: mean_x [23:0], mean_y [47:24], covering_radius [71:48],
	// circle_count [77:72], overflow_flag [78], zero [79]
	output logic [79:0] m_axis_tdata
);
	import csbc_pkg::*;

	// Circle store, written on load and read one entry at a time in the walk.
	logic [63:0] store_mem [SetCapacity];
	logic [63:0] rd_s1;

	state_t state_q;
	logic use_radii_q;
	logic signed [SumW-1:0] sum_x_q, sum_y_q;
	logic [CntW-1:0] count_q;
	logic [IdxW-1:0] idx_q;
	logic dropped_q;
	logic signed [23:0] mx_q, my_q;
	logic signed [25:0] dx_q, dy_q;
	logic [49:0] d2_q;
	logic sq_phase_q;
	logic [24:0] best_q;
	logic [15:0] rad_q;
	logic valid_q;
	logic [79:0] out_q;

	logic accept;
	logic full;
	div_ctl_t div_ctl;
	logic div_done, sq_start, sq_done;
	logic signed [23:0] quotient;
	logic [RootW-1:0] root;
	logic [25:0] cand;
	logic [23:0] rad_out;
	logic [25:0] mag_x, mag_y;
	logic [49:0] prod;
	logic signed [SumW-1:0] div_in;
	logic sat;
	logic last_idx;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_LOAD);
	assign full = (count_q == CntW'(SetCapacity));
	assign div_in = (state_q == ST_DIVY) ? sum_y_q : sum_x_q;
	assign last_idx = ({1'b0, idx_q} == count_q - 1'b1);

	// Squaring reuses one multiplier: first dx, then dy.
	assign mag_x = dx_q[25] ? -dx_q : dx_q;
	assign mag_y = dy_q[25] ? -dy_q : dy_q;
	assign prod = sq_phase_q ? mag_y[24:0] * mag_y[24:0] : mag_x[24:0] * mag_x[24:0];
	assign cand = {1'b0, root} + {10'd0, rad_q};
	assign sat = best_q[24];
	assign rad_out = sat ? 24'hFFFFFF : best_q[23:0];

	always_ff @(posedge clk) begin
		if (accept && !full) begin
			store_mem[count_q[IdxW-1:0]] <= s_axis_tdata;
		end
		rd_s1 <= store_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			use_radii_q <= 1'b1;
			sum_x_q <= '0;
			sum_y_q <= '0;
			count_q <= '0;
			dropped_q <= 1'b0;
			idx_q <= '0;
			valid_q <= 1'b0;
			sq_phase_q <= 1'b0;
			div_ctl <= '0;
		end else begin
			div_ctl.start <= 1'b0;
			if (cfg_wr_en) begin
				use_radii_q <= cfg_wr_data;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (!full) begin
							sum_x_q <= sum_x_q + SumW'($signed(s_axis_tdata[23:0]));
							sum_y_q <= sum_y_q + SumW'($signed(s_axis_tdata[47:24]));
							count_q <= count_q + 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							state_q <= ST_DIVX;
							div_ctl <= '{start: 1'b1, busy: 1'b1};
						end
					end
				end
				ST_DIVX: begin
					if (div_done) begin
						state_q <= ST_DIVY;
						div_ctl.start <= 1'b1;
					end
				end
				ST_DIVY: begin
					if (div_done) begin
						div_ctl.busy <= 1'b0;
						idx_q <= '0;
						state_q <= use_radii_q ? ST_READ : ST_OUT;
					end
				end
				ST_READ: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					sq_phase_q <= 1'b0;
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					sq_phase_q <= ~sq_phase_q;
					if (sq_phase_q) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sq_done) begin
						if (last_idx) begin
							state_q <= ST_OUT;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_OUT: begin
					if (!valid_q) begin
						valid_q <= 1'b1;
					end else if (m_axis_tready) begin
						valid_q <= 1'b0;
						sum_x_q <= '0;
						sum_y_q <= '0;
						count_q <= '0;
						dropped_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_DIVX && div_done) begin
			mx_q <= quotient;
			best_q <= '0;
		end
		if (state_q == ST_DIVY && div_done) begin
			my_q <= quotient;
		end
		if (state_q == ST_DIFF) begin
			dx_q <= 26'($signed(rd_s1[23:0])) - 26'(mx_q);
			dy_q <= 26'($signed(rd_s1[47:24])) - 26'(my_q);
			rad_q <= rd_s1[63:48];
		end
		if (state_q == ST_SQR) begin
			d2_q <= sq_phase_q ? d2_q + prod : prod;
		end
		if (state_q == ST_ROOT && sq_done && cand > {1'b0, best_q}) begin
			best_q <= cand[24:0] | {cand[25], 24'd0};
		end
		if (state_q == ST_OUT && !valid_q) begin
			out_q <= {1'b0, dropped_q || (use_radii_q && sat), 6'(count_q),
				use_radii_q ? rad_out : 24'd0, my_q, mx_q};
		end
	end

	assign sq_start = (state_q == ST_SQR) && sq_phase_q;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = out_q;

	csbc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_ctl.start),
		.dividend(div_in), .divisor(count_q),
		.done(div_done), .quotient(quotient)
	);

	csbc_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.radicand(d2_q + prod), .done(sq_done), .root(root)
	);

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_busy_not_ready, clk, arst_n, state_q != ST_LOAD, !s_axis_tready)
	`ASSERT_IMPL(a_valid_in_out, clk, arst_n, m_axis_tvalid, state_q == ST_OUT)
	`ASSERT_IMPL(a_count_range, clk, arst_n, 1'b1, count_q <= CntW'(SetCapacity))
endmodule
